### design/apvd_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants for the adpcm/pcm voice decoder
package apvd_pkg;

    localparam logic [1:0] OP_KEY_ON  = 2'd0;
    localparam logic [1:0] OP_DECODE  = 2'd1;
    localparam logic [1:0] OP_KEY_OFF = 2'd2;

    localparam logic [1:0] MODE_SILENT = 2'd0;
    localparam logic [1:0] MODE_ADPCM  = 2'd1;
    localparam logic [1:0] MODE_PCM8   = 2'd2;
    localparam logic [1:0] MODE_PCM16  = 2'd3;

    localparam logic [2:0] CFG_PLAY_MODE       = 3'd0;
    localparam logic [2:0] CFG_LOOP_ENABLE     = 3'd1;
    localparam logic [2:0] CFG_START_ADDR      = 3'd2;
    localparam logic [2:0] CFG_LOOP_START_ADDR = 3'd3;
    localparam logic [2:0] CFG_LOOP_END_ADDR   = 3'd4;
    localparam logic [2:0] CFG_STOP_ADDR       = 3'd5;

    localparam logic [14:0] STEP_MAX  = 15'h6000;
    localparam logic [14:0] STEP_MIN  = 15'h007f;
    localparam logic [14:0] STEP_INIT = 15'd127;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] mem_word;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [23:0]        next_byte_addr;
        logic               is_playing;
        logic               reached_end;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  play_mode;
        logic        loop_enable;
        logic [23:0] start_byte_addr;
        logic [23:0] loop_start_byte_addr;
        logic [23:0] loop_end_byte_addr;
        logic [23:0] stop_byte_addr;
    } t_cfg;

    function automatic logic [9:0] scale_of(input logic [2:0] code);
        logic [9:0] s;
        case (code) inside
            [3'd0:3'd3]: s = 10'h0e6;
            3'd4:        s = 10'h133;
            3'd5:        s = 10'h199;
            3'd6:        s = 10'h200;
            default:     s = 10'h266;
        endcase
        return s;
    endfunction

endpackage

### design/adpcm_pcm_voice_decoder.sv
`timescale 1ns / 1ps
// top level: input register, voice datapath, result register, config registers
// a result passes through the input register, then the result register
// throughput: one item per cycle while the output is not stalled; the voice
// state updates once per item, so consecutive items never wait on each other
// reset (synchronous, active low): config registers to 0, voice silent,
// predictor cleared and step size 127, both pipeline stages empty
module adpcm_pcm_voice_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  apvd_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output apvd_pkg::t_out_item  o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [23:0]          i_cfg_data
);
    import apvd_pkg::*;

    t_in_item  r_in;
    logic      r_in_vld;
    t_out_item r_out;
    logic      r_out_vld;
    t_cfg      r_cfg;
    t_out_item w_result;
    logic      w_out_free;
    logic      w_fire;

    assign w_out_free  = !r_out_vld || i_out_ready;
    assign w_fire      = r_in_vld && w_out_free;
    assign o_in_ready  = !r_in_vld || w_out_free;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    apvd_voice u_voice (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_vld <= w_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    // config write transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PLAY_MODE:       r_cfg.play_mode            <= i_cfg_data[1:0];
                CFG_LOOP_ENABLE:     r_cfg.loop_enable          <= i_cfg_data[0];
                CFG_START_ADDR:      r_cfg.start_byte_addr      <= i_cfg_data;
                CFG_LOOP_START_ADDR: r_cfg.loop_start_byte_addr <= i_cfg_data;
                CFG_LOOP_END_ADDR:   r_cfg.loop_end_byte_addr   <= i_cfg_data;
                CFG_STOP_ADDR:       r_cfg.stop_byte_addr       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_end_stops_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.reached_end && r_out.is_playing))
        else $error("reached_end with voice still playing");

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_vld && r_out_vld))
        else $error("input stalled with a free stage");

    a_key_item_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.opcode != OP_DECODE) |=> (r_out.sample == 16'sd0))
        else $error("non-decode item produced a sample");

    a_key_on_plays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.opcode == OP_KEY_ON) |=> (r_out_vld && r_out.is_playing))
        else $error("key-on did not start the voice");
`endif

endmodule

### design/apvd_adpcm.sv
`timescale 1ns / 1ps
// one adpcm nibble: predictor and step size update with saturation
module apvd_adpcm (
    input  logic               i_odd,
    input  logic [15:0]        i_word,
    input  logic signed [15:0] i_signal,
    input  logic [14:0]        i_step,
    output logic signed [15:0] o_signal,
    output logic [14:0]        o_step
);
    import apvd_pkg::*;

    logic [3:0]         w_nib;
    logic [3:0]         w_mag;
    logic [18:0]        w_prod;
    logic [15:0]        w_delta;
    logic signed [17:0] w_base;
    logic signed [17:0] w_sum;
    logic [24:0]        w_scaled;
    logic [16:0]        w_step_raw;

    assign w_nib    = i_odd ? i_word[11:8] : i_word[15:12];
    assign w_mag    = {w_nib[2:0], 1'b1};
    assign w_prod   = 19'(i_step) * 19'(w_mag);
    // magnitude shift equals truncation toward zero
    assign w_delta  = w_prod[18:3];
    assign w_base   = {{2{i_signal[15]}}, i_signal};
    assign w_sum    = w_nib[3] ? (w_base - $signed({2'b00, w_delta}))
                               : (w_base + $signed({2'b00, w_delta}));
    assign w_scaled = 25'(i_step) * 25'(scale_of(w_nib[2:0]));
    assign w_step_raw = w_scaled[24:8];

    always_comb begin
        if (w_sum > 18'sd32767) begin
            o_signal = 16'sh7fff;
        end else if (w_sum < -18'sd32768) begin
            o_signal = 16'sh8000;
        end else begin
            o_signal = w_sum[15:0];
        end

        if (w_step_raw > 17'(STEP_MAX)) begin
            o_step = STEP_MAX;
        end else if (w_step_raw < 17'(STEP_MIN)) begin
            o_step = STEP_MIN;
        end else begin
            o_step = w_step_raw[14:0];
        end
    end

endmodule

### design/apvd_voice.sv
`timescale 1ns / 1ps
// voice state: position, predictor, loop save/restore, key on/off and stop
module apvd_voice (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  apvd_pkg::t_in_item    i_item,
    input  apvd_pkg::t_cfg        i_cfg,
    output apvd_pkg::t_out_item   o_result
);
    import apvd_pkg::*;

    logic [24:0]        r_pos,         n_pos;
    logic signed [15:0] r_signal,      n_signal;
    logic [14:0]        r_step,        n_step;
    logic signed [15:0] r_save_signal, n_save_signal;
    logic [14:0]        r_save_step,   n_save_step;
    logic               r_loop_taken,  n_loop_taken;
    logic               r_active,      n_active;

    logic signed [15:0] w_dec_signal;
    logic [14:0]        w_dec_step;
    logic [24:0]        w_ls;
    logic [24:0]        w_le;
    logic [24:0]        w_st;
    logic [24:0]        w_inc;
    logic [24:0]        w_pos_adv;
    logic [24:0]        w_pos_new;
    logic signed [15:0] w_sample;
    logic               w_ended;

    apvd_adpcm u_adpcm (
        .i_odd    (r_pos[0]),
        .i_word   (i_item.mem_word),
        .i_signal (r_signal),
        .i_step   (r_step),
        .o_signal (w_dec_signal),
        .o_step   (w_dec_step)
    );

    assign w_ls = {i_cfg.loop_start_byte_addr, 1'b0};
    assign w_le = {i_cfg.loop_end_byte_addr, 1'b0};
    assign w_st = {i_cfg.stop_byte_addr, 1'b0};

    always_comb begin
        case (i_cfg.play_mode)
            MODE_ADPCM: w_inc = 25'd1;
            MODE_PCM8:  w_inc = 25'd2;
            default:    w_inc = 25'd4;
        endcase
    end

    assign w_pos_adv = r_pos + w_inc;

    always_comb begin
        n_pos         = r_pos;
        n_signal      = r_signal;
        n_step        = r_step;
        n_save_signal = r_save_signal;
        n_save_step   = r_save_step;
        n_loop_taken  = r_loop_taken;
        n_active      = r_active;
        w_pos_new     = w_pos_adv;
        w_sample      = '0;
        w_ended       = 1'b0;

        case (i_item.opcode)
            OP_KEY_ON: begin
                n_pos         = {i_cfg.start_byte_addr, 1'b0};
                n_signal      = '0;
                n_save_signal = '0;
                n_step        = STEP_INIT;
                n_save_step   = STEP_INIT;
                n_loop_taken  = 1'b0;
                n_active      = 1'b1;
            end
            OP_KEY_OFF: begin
                n_active = 1'b0;
            end
            OP_DECODE: begin
                if (r_active && i_cfg.play_mode != MODE_SILENT) begin
                    if (i_cfg.play_mode == MODE_ADPCM) begin
                        w_sample = w_dec_signal;
                        n_signal = w_dec_signal;
                        n_step   = w_dec_step;
                        if (i_cfg.loop_enable && w_pos_adv == w_ls && !r_loop_taken) begin
                            n_save_signal = w_dec_signal;
                            n_save_step   = w_dec_step;
                        end
                        if (i_cfg.loop_enable && w_pos_adv >= w_le) begin
                            w_pos_new    = w_ls;
                            n_signal     = n_save_signal;
                            n_step       = n_save_step;
                            n_loop_taken = 1'b1;
                        end
                    end else begin
                        if (i_cfg.play_mode == MODE_PCM8) begin
                            w_sample = {i_item.mem_word[15:8], 8'h00};
                        end else begin
                            w_sample = i_item.mem_word;
                        end
                        if (i_cfg.loop_enable && w_pos_adv >= w_le) begin
                            w_pos_new = w_ls;
                        end
                    end
                    if (w_pos_new >= w_st) begin
                        w_ended  = 1'b1;
                        n_active = 1'b0;
                    end
                    n_pos = w_pos_new;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.sample         = w_sample;
        o_result.next_byte_addr = n_pos[24:1];
        o_result.is_playing     = n_active;
        o_result.reached_end    = w_ended;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_signal      <= '0;
            r_step        <= STEP_INIT;
            r_save_signal <= '0;
            r_save_step   <= STEP_INIT;
            r_loop_taken  <= 1'b0;
            r_active      <= 1'b0;
        end else if (i_fire) begin
            r_pos         <= n_pos;
            r_signal      <= n_signal;
            r_step        <= n_step;
            r_save_signal <= n_save_signal;
            r_save_step   <= n_save_step;
            r_loop_taken  <= n_loop_taken;
            r_active      <= n_active;
        end
    end

endmodule
